// File: rtl/core/crrt_pkg.sv
// crrt_pkg: shared types and constants for the chained range remap table
// holds item kinds, channel payload structs and the stored window word
// no dependencies
`default_nettype none

package crrt_pkg;

  // default table geometry
  localparam int STAGES_DEF  = 7;
  localparam int ENTRIES_DEF = 16;

  // item kinds
  localparam logic [1:0] KIND_WRITE     = 2'd0;
  localparam logic [1:0] KIND_TRANSLATE = 2'd1;
  localparam logic [1:0] KIND_CLEAR     = 2'd2;

  // input item payload
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  stage;
    logic [3:0]  slot;
    logic        entry_valid;
    logic [31:0] dest_start;
    logic [31:0] src_start;
    logic [31:0] range_len;
    logic [31:0] seed_value;
  } in_t;

  // result item payload
  typedef struct packed {
    logic        is_translation;
    logic [31:0] location;
    logic [31:0] min_location;
    logic        dest_overflow;
  } out_t;

  // one stored window
  typedef struct packed {
    logic        active;
    logic [31:0] dest;
    logic [31:0] src;
    logic [31:0] len;
  } win_t;

  // outcome of testing one window against a value
  typedef struct packed {
    logic        hit;
    logic [31:0] value;
    logic        wrap;
  } match_t;

endpackage

`default_nettype wire

// File: rtl/core/crrt_window_match.sv
// crrt_window_match: tests one window against a value and forms its remap
// 33-bit range compare, dest + (v - src) with wrap flag
// depends on crrt_pkg
`default_nettype none

module crrt_window_match (
  input  wire logic [31:0]     value,
  input  wire crrt_pkg::win_t  win,
  output crrt_pkg::match_t     result
);

  logic [32:0] lo;
  logic [32:0] hi;
  logic [32:0] v_ext;
  logic [32:0] offset;
  logic [32:0] sum;

  // range bounds at 33 bits so src + len never wraps
  assign lo     = {1'b0, win.src};
  assign hi     = lo + {1'b0, win.len};
  assign v_ext  = {1'b0, value};

  // offset is only used when value >= src
  assign offset = v_ext - lo;
  assign sum    = {1'b0, win.dest} + offset;

  assign result.hit   = win.active && (v_ext >= lo) && (v_ext < hi);
  assign result.value = sum[31:0];
  assign result.wrap  = sum[32];

endmodule

`default_nettype wire

// File: rtl/core/chained_range_remap_table_core.sv
// chained_range_remap_table_core: windows of all stages in one synchronous memory
// write / clear / unused items: result registered in the cycle after the transfer, one per cycle unless out_stall holds
// translate items: STAGES*ENTRIES window reads, one per cycle on the single memory port;
//   result registered from S_FIN once the output is free; no new transfer until back in S_IDLE
// reset: a clearing pass over all STAGES*ENTRIES windows zeroes every active bit; in_stall
//   stays high meanwhile, running minimum resets to all ones
`default_nettype none

module chained_range_remap_table_core #(
  parameter int STAGES  = crrt_pkg::STAGES_DEF,
  parameter int ENTRIES = crrt_pkg::ENTRIES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire crrt_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output crrt_pkg::out_t      out_data
);

  localparam int DEPTH  = STAGES * ENTRIES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [3:0] {
    S_INIT = 4'b0001,
    S_IDLE = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   iss_addr_r, iss_addr_nxt;
  logic [ENT_W-1:0]    iss_ent_r, iss_ent_nxt;
  logic                iss_on_r, iss_on_nxt;
  logic                tag_vld_r, tag_vld_nxt;
  logic                tag_end_stage_r, tag_end_stage_nxt;
  logic                tag_end_all_r, tag_end_all_nxt;
  logic [31:0]         v_r, v_nxt;
  logic                ovf_r, ovf_nxt;
  logic                hit_stage_r, hit_stage_nxt;
  logic [31:0]         run_min_r, run_min_nxt;
  logic                out_valid_r, out_valid_nxt;
  crrt_pkg::out_t      out_data_r, out_data_nxt;

  crrt_pkg::win_t      mem [DEPTH];
  crrt_pkg::win_t      rd_data_r;
  logic [ADDR_W-1:0]   mem_addr;
  logic                mem_we;
  crrt_pkg::win_t      mem_wdata;

  logic                in_xfer;
  logic                out_free;
  logic                wr_ok;
  logic [31:0]         wr_lin;
  crrt_pkg::match_t    match;
  logic [31:0]         fin_min;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) ||
                    (!out_free && (in_data.kind != crrt_pkg::KIND_TRANSLATE));
  assign in_xfer  = in_valid && !in_stall;

  // window write address and range check
  assign wr_lin = 32'(in_data.stage) * 32'(ENTRIES) + 32'(in_data.slot);
  assign wr_ok  = (32'(in_data.stage) < 32'(STAGES)) &&
                  (32'(in_data.slot) < 32'(ENTRIES));

  // single memory port: clearing pass, window writes, scan reads
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    mem_addr  = iss_addr_r;
    if (state_r == S_INIT) begin
      mem_we = 1'b1;
    end else if (state_r == S_IDLE) begin
      mem_addr  = ADDR_W'(wr_lin);
      mem_we    = in_xfer && (in_data.kind == crrt_pkg::KIND_WRITE) && wr_ok;
      mem_wdata = '{active: in_data.entry_valid, dest: in_data.dest_start,
                    src: in_data.src_start, len: in_data.range_len};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_addr];
  end

  // compare the returned window against the value in flight
  crrt_window_match u_match (
    .value  (v_r),
    .win    (rd_data_r),
    .result (match)
  );

  assign fin_min = (v_r < run_min_r) ? v_r : run_min_r;

  // control and datapath next state
  always_comb begin
    state_nxt         = state_r;
    iss_addr_nxt      = iss_addr_r;
    iss_ent_nxt       = iss_ent_r;
    iss_on_nxt        = iss_on_r;
    tag_vld_nxt       = 1'b0;
    tag_end_stage_nxt = 1'b0;
    tag_end_all_nxt   = 1'b0;
    v_nxt             = v_r;
    ovf_nxt           = ovf_r;
    hit_stage_nxt     = hit_stage_r;
    run_min_nxt       = run_min_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_data_nxt      = out_data_r;

    case (state_r)
      S_INIT: begin
        if (iss_addr_r == ADDR_W'(DEPTH - 1)) begin
          iss_addr_nxt = '0;
          state_nxt    = S_IDLE;
        end else begin
          iss_addr_nxt = iss_addr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          if (in_data.kind == crrt_pkg::KIND_TRANSLATE) begin
            iss_addr_nxt  = '0;
            iss_ent_nxt   = '0;
            iss_on_nxt    = 1'b1;
            v_nxt         = in_data.seed_value;
            ovf_nxt       = 1'b0;
            hit_stage_nxt = 1'b0;
            state_nxt     = S_SCAN;
          end else begin
            // write, clear and the unused kind answer at once
            if (in_data.kind == crrt_pkg::KIND_CLEAR) begin
              run_min_nxt = '1;
            end
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{is_translation: 1'b0, location: 32'd0,
                              min_location: (in_data.kind == crrt_pkg::KIND_CLEAR) ?
                                            32'hFFFF_FFFF : run_min_r,
                              dest_overflow: 1'b0};
          end
        end
      end

      S_SCAN: begin
        // issue one window read per cycle, tagged with its position
        if (iss_on_r) begin
          tag_vld_nxt       = 1'b1;
          tag_end_stage_nxt = (iss_ent_r == ENT_W'(ENTRIES - 1));
          tag_end_all_nxt   = (iss_addr_r == ADDR_W'(DEPTH - 1));
          iss_ent_nxt       = tag_end_stage_nxt ? '0 : iss_ent_r + 1'b1;
          if (tag_end_all_nxt) begin
            iss_on_nxt = 1'b0;
          end else begin
            iss_addr_nxt = iss_addr_r + 1'b1;
          end
        end
        // first hit of a stage remaps the value, later windows are skipped
        if (tag_vld_r) begin
          if (match.hit && !hit_stage_r) begin
            v_nxt         = match.value;
            ovf_nxt       = ovf_r | match.wrap;
            hit_stage_nxt = 1'b1;
          end
          if (tag_end_stage_r) begin
            hit_stage_nxt = 1'b0;
          end
          if (tag_end_all_r) begin
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          run_min_nxt   = fin_min;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{is_translation: 1'b1, location: v_r,
                            min_location: fin_min, dest_overflow: ovf_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_INIT;
      iss_addr_r      <= '0;
      iss_ent_r       <= '0;
      iss_on_r        <= 1'b0;
      tag_vld_r       <= 1'b0;
      tag_end_stage_r <= 1'b0;
      tag_end_all_r   <= 1'b0;
      hit_stage_r     <= 1'b0;
      run_min_r       <= '1;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      iss_addr_r      <= iss_addr_nxt;
      iss_ent_r       <= iss_ent_nxt;
      iss_on_r        <= iss_on_nxt;
      tag_vld_r       <= tag_vld_nxt;
      tag_end_stage_r <= tag_end_stage_nxt;
      tag_end_all_r   <= tag_end_all_nxt;
      hit_stage_r     <= hit_stage_nxt;
      run_min_r       <= run_min_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    ovf_r      <= ovf_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_translate_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_data.kind == crrt_pkg::KIND_TRANSLATE) |=> state_r == S_SCAN)
    else $error("translate transfer did not start a scan");

  a_last_read_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    tag_vld_r && tag_end_all_r |=> state_r == S_FIN)
    else $error("last window read did not end the scan");

  a_no_read_outside_scan: assert property (@(posedge clk) disable iff (!rst_n)
    iss_on_r |-> state_r == S_SCAN)
    else $error("window reads issued outside a scan");

  a_min_bounds_location: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.is_translation |->
      out_data_r.min_location <= out_data_r.location)
    else $error("running minimum above reported location");

endmodule

`default_nettype wire

// File: verif/tb.sv
// tb: self-checking testbench for chained_range_remap_table_core
// directed table then random write / translate / clear / unused-kind traffic, scored by an in-file predictor
// depends on crrt_pkg and chained_range_remap_table_core
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crrt_pkg::*;

  localparam int STAGES       = STAGES_DEF;
  localparam int ENTRIES      = ENTRIES_DEF;
  localparam int DEPTH        = STAGES * ENTRIES;
  localparam int DIRECTED_N   = 23;
  localparam int RANDOM_ITEMS = 530;
  localparam int TOTAL_ITEMS  = DIRECTED_N + RANDOM_ITEMS;
  localparam int QUIET_TAIL   = 60;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 20;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam logic [31:0] ALL_ONES    = 32'hFFFFFFFF;
  localparam out_t        UNTYPED     = '0;

  // one row of the directed table
  typedef struct packed {
    in_t  item;
    logic typed;
    out_t want;
  } row_t;

  // kind, stage, slot, valid, dest, src, len, seed / typed flag / typed result
  localparam row_t DIRECTED [DIRECTED_N] = '{
    '{'{KIND_TRANSLATE, 3'd0, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
      '{1'b1, 32'h0, 32'h0, 1'b0}},
    '{'{KIND_TRANSLATE, 3'd0, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, ALL_ONES}, 1'b1,
      '{1'b1, ALL_ONES, 32'h0, 1'b0}},
    '{'{KIND_CLEAR, 3'd0, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
      '{1'b0, 32'h0, ALL_ONES, 1'b0}},
    '{'{KIND_TRANSLATE, 3'd0, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, ALL_ONES}, 1'b1,
      '{1'b1, ALL_ONES, ALL_ONES, 1'b0}},
    // undefined kind changes nothing
    '{'{KIND_UNUSED, 3'd0, 4'd0, 1'b1, 32'h0, 32'h0, ALL_ONES, 32'h0}, 1'b1,
      '{1'b0, 32'h0, ALL_ONES, 1'b0}},
    // stage beyond the table is dropped
    '{'{KIND_WRITE, 3'd7, 4'd0, 1'b1, 32'h55, 32'h0, ALL_ONES, 32'h0}, 1'b1,
      '{1'b0, 32'h0, ALL_ONES, 1'b0}},
    '{'{KIND_TRANSLATE, 3'd0, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h1234}, 1'b1,
      '{1'b1, 32'h1234, 32'h1234, 1'b0}},
    // overlapping windows, lower slot wins
    '{'{KIND_WRITE, 3'd0, 4'd15, 1'b1, 32'h1000, 32'h0, 32'h10, 32'h0}, 1'b0, UNTYPED},
    '{'{KIND_WRITE, 3'd0, 4'd0, 1'b1, 32'hFFFFFFF0, 32'h8, 32'h20, 32'h0}, 1'b0, UNTYPED},
    '{'{KIND_TRANSLATE, 3'd0, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h10}, 1'b0, UNTYPED},
    '{'{KIND_TRANSLATE, 3'd0, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h20}, 1'b0, UNTYPED},
    '{'{KIND_TRANSLATE, 3'd0, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h4}, 1'b0, UNTYPED},
    // zero length window matches nothing
    '{'{KIND_WRITE, 3'd6, 4'd3, 1'b1, 32'h0, 32'h7000, 32'h0, 32'h0}, 1'b0, UNTYPED},
    '{'{KIND_TRANSLATE, 3'd0, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h7000}, 1'b0, UNTYPED},
    // window reaching past 2^32
    '{'{KIND_WRITE, 3'd3, 4'd7, 1'b1, 32'h0, 32'hFFFFFFF0, ALL_ONES, 32'h0}, 1'b0, UNTYPED},
    '{'{KIND_TRANSLATE, 3'd0, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, ALL_ONES}, 1'b0, UNTYPED},
    // removing a window
    '{'{KIND_WRITE, 3'd0, 4'd0, 1'b0, 32'hFFFFFFF0, 32'h8, 32'h20, 32'h0}, 1'b0, UNTYPED},
    '{'{KIND_TRANSLATE, 3'd0, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h10}, 1'b0, UNTYPED},
    '{'{KIND_WRITE, 3'd0, 4'd15, 1'b1, ALL_ONES, 32'h0, ALL_ONES, 32'h0}, 1'b0, UNTYPED},
    '{'{KIND_TRANSLATE, 3'd0, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h12345678}, 1'b0, UNTYPED},
    '{'{KIND_CLEAR, 3'd0, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, UNTYPED},
    '{'{KIND_WRITE, 3'd6, 4'd15, 1'b1, 32'hA5A5A5A5, 32'h5A5A5A5A, 32'h100, 32'h0}, 1'b0,
      UNTYPED},
    '{'{KIND_WRITE, 3'd3, 4'd7, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, UNTYPED}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  // predictor copy of the window tables and running minimum
  logic [31:0] win_dest [DEPTH];
  logic [31:0] win_src [DEPTH];
  logic [31:0] win_len [DEPTH];
  logic        win_active [DEPTH];
  logic [31:0] lowest_loc;

  out_t        awaited_results [$];
  logic [31:0] base_pool [8];
  int          sent_cnt   = 0;
  int          errors     = 0;
  int          cycles     = 0;
  logic        held_long  = 1'b0;
  logic        idle_ok;

  chained_range_remap_table_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // idling in stretches, none in the tail of the run
  assign idle_ok = (sent_cnt < TOTAL_ITEMS - QUIET_TAIL) && (((sent_cnt / 40) % 3) != 2);

  // one stage: first active window holding v remaps it, 33-bit range compare
  function automatic logic [31:0] stage_lookup(input logic [31:0] v, input int st,
                                               inout logic wrapped);
    logic [32:0] lo;
    logic [32:0] hi;
    logic [32:0] sum;
    int          k;
    int          e;
    for (e = 0; e < ENTRIES; e++) begin
      k = st * ENTRIES + e;
      if (win_active[k]) begin
        lo = {1'b0, win_src[k]};
        hi = lo + {1'b0, win_len[k]};
        if ({1'b0, v} >= lo && {1'b0, v} < hi) begin
          sum = {1'b0, win_dest[k]} + ({1'b0, v} - lo);
          if (sum[32]) wrapped = 1'b1;
          return sum[31:0];
        end
      end
    end
    return v;
  endfunction

  // apply one accepted item to the predictor and return its result
  function automatic out_t remap_item(input in_t it);
    out_t        r;
    logic [31:0] v;
    logic        wrapped;
    int          k;
    int          st;
    r       = '0;
    wrapped = 1'b0;
    case (it.kind)
      KIND_WRITE: begin
        if (int'(it.stage) < STAGES && int'(it.slot) < ENTRIES) begin
          k             = int'(it.stage) * ENTRIES + int'(it.slot);
          win_active[k] = it.entry_valid;
          win_dest[k]   = it.dest_start;
          win_src[k]    = it.src_start;
          win_len[k]    = it.range_len;
        end
      end
      KIND_TRANSLATE: begin
        v = it.seed_value;
        for (st = 0; st < STAGES; st++) v = stage_lookup(v, st, wrapped);
        if (v < lowest_loc) lowest_loc = v;
        r.is_translation = 1'b1;
        r.location       = v;
      end
      KIND_CLEAR: lowest_loc = ALL_ONES;
      default: ;
    endcase
    r.min_location  = lowest_loc;
    r.dest_overflow = wrapped;
    return r;
  endfunction

  // value near one of a few bases, so windows chain and seeds hit them
  function automatic logic [31:0] pick_point();
    return base_pool[$urandom_range(0, 7)] + 32'($urandom_range(0, 300));
  endfunction

  // random item, mostly window writes and translations
  function automatic in_t random_item();
    in_t it;
    int  roll;
    int  len_roll;
    it.stage       = ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, STAGES - 1));
    it.slot        = 4'($urandom_range(0, 15));
    it.entry_valid = ($urandom_range(0, 3) != 0);
    it.dest_start  = ($urandom_range(0, 9) == 0) ? $urandom : pick_point();
    it.src_start   = ($urandom_range(0, 9) == 0) ? $urandom : pick_point();
    len_roll       = $urandom_range(0, 99);
    if (len_roll < 8)       it.range_len = 32'h0;
    else if (len_roll < 18) it.range_len = $urandom;
    else                    it.range_len = 32'($urandom_range(1, 512));
    it.seed_value  = ($urandom_range(0, 4) == 0) ? $urandom : pick_point();
    roll           = $urandom_range(0, 99);
    if (roll < 45)      it.kind = KIND_WRITE;
    else if (roll < 88) it.kind = KIND_TRANSLATE;
    else if (roll < 96) it.kind = KIND_CLEAR;
    else                it.kind = KIND_UNUSED;
    return it;
  endfunction

  // offer one item from a falling edge, return at the falling edge after its transfer
  task automatic send_item(input in_t item, input logic typed, input out_t want);
    out_t predicted;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = remap_item(item);
    awaited_results.push_back(typed ? want : predicted);
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
    end
  endtask

  // stimulus: reset, directed table, random traffic, drain
  initial begin : stimulus
    int i;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    lowest_loc = ALL_ONES;
    for (i = 0; i < DEPTH; i++) win_active[i] = 1'b0;
    base_pool[0] = 32'h0;
    base_pool[1] = ALL_ONES - 32'h100;
    for (i = 2; i < 8; i++) base_pool[i] = $urandom;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIRECTED_N; i++)
      send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      // let the block drain completely once mid-run
      if (i == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        wait (awaited_results.size() == 0);
        @(negedge clk);
      end
      send_item(random_item(), 1'b0, UNTYPED);
    end
    in_valid <= 1'b0;

    wait (awaited_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result side stall: short random bursts plus one long hold
  initial begin : result_sink
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held_long && sent_cnt >= 250) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // score each result transfer against the oldest prediction
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result with none pending: expected nothing, actual %h", $time,
                 out_data);
      end else begin
        want = awaited_results.pop_front();
        check_field("is_translation", 32'(want.is_translation), 32'(out_data.is_translation));
        check_field("location", want.location, out_data.location);
        check_field("min_location", want.min_location, out_data.min_location);
        check_field("dest_overflow", 32'(want.dest_overflow), 32'(out_data.dest_overflow));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

// File: filelist.f
rtl/core/crrt_pkg.sv
rtl/core/crrt_window_match.sv
rtl/core/chained_range_remap_table_core.sv
verif/tb.sv
